// ----- rtl/round_robin_pool_allocator_assert.svh -----
// Assertion macros shared by the checker files of the pool allocator.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ROUND_ROBIN_POOL_ALLOCATOR_ASSERT_SVH
`define ROUND_ROBIN_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define RRPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pool allocator check failed (same cycle)");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define RRPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pool allocator check failed (next cycle)");

`endif

// ----- rtl/rrpa_pkg.sv -----
// Shared types, constants and helpers of the round-robin pool allocator.
// No dependencies; used by rrpa_slot_eval and round_robin_pool_allocator.
`timescale 1ns / 1ps

package rrpa_pkg;

	typedef enum logic [1:0] {
		ACT_ACQUIRE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_FAIL    = 2'd2,
		ACT_TICK    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POINT,
		ST_SCAN,
		ST_SLOT,
		ST_TICK,
		ST_TALLY,
		ST_DONE
	} state_t;

	localparam logic [3:0] FAIL_LIMIT     = 4'd3;
	localparam logic [3:0] RECREATE_LIMIT = 4'd5;
	localparam logic [3:0] RESET_CEILING  = 4'd6;
	localparam logic [3:0] COUNT_MAX      = 4'd15;
	// Largest pool size the 4-bit register can express.
	localparam int unsigned CFG_SIZE_MAX  = 15;

	typedef struct packed {
		logic       busy;
		logic [3:0] count;
		logic       ready;
		logic       reset_ok;
		logic       recreate_ok;
	} slot_in_t;

	typedef struct packed {
		logic       hit;
		logic       failed;
		logic       write;
		logic       busy_nxt;
		logic [3:0] count_nxt;
	} slot_res_t;

	function automatic logic mask_bit(input logic [7:0] mask, input logic [3:0] idx);
		return (idx < 4'd8) ? mask[idx[2:0]] : 1'b0;
	endfunction

endpackage

// ----- rtl/rrpa_slot_eval.sv -----
// Shared per-slot evaluation unit: decides grant eligibility and the next busy flag and
// failure count of one slot for one action. Depends on rrpa_pkg.
`timescale 1ns / 1ps

module rrpa_slot_eval (
	input  rrpa_pkg::action_t   op,
	input  rrpa_pkg::slot_in_t  slot,
	output rrpa_pkg::slot_res_t res
);

	logic       failed;
	logic [3:0] bumped;

	assign failed = slot.count >= rrpa_pkg::FAIL_LIMIT;
	assign bumped = (slot.count < rrpa_pkg::COUNT_MAX) ? slot.count + 4'd1 : slot.count;

	always_comb begin
		res.hit       = !slot.busy && !failed && slot.ready;
		res.failed    = failed;
		res.write     = 1'b1;
		res.busy_nxt  = slot.busy;
		res.count_nxt = slot.count;
		case (op)
			rrpa_pkg::ACT_ACQUIRE: begin
				res.write    = res.hit;
				res.busy_nxt = 1'b1;
			end
			rrpa_pkg::ACT_RELEASE: begin
				res.busy_nxt = 1'b0;
			end
			rrpa_pkg::ACT_FAIL: begin
				res.busy_nxt = 1'b0;
				// a connection reset clears a freshly failed slot
				if ((bumped inside {[rrpa_pkg::FAIL_LIMIT : rrpa_pkg::RESET_CEILING - 4'd1]})
						&& slot.reset_ok) begin
					res.count_nxt = 4'd0;
				end else begin
					res.count_nxt = bumped;
				end
			end
			rrpa_pkg::ACT_TICK: begin
				if (failed && !slot.busy) begin
					if (slot.reset_ok && slot.ready) begin
						res.count_nxt = 4'd0;
					end else if ((slot.count >= rrpa_pkg::RECREATE_LIMIT) && slot.recreate_ok) begin
						res.count_nxt = 4'd0;
					end
				end
			end
			default: begin
				res.write = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/round_robin_pool_allocator.sv -----
// Top level of the round-robin pool allocator: sequencer, slot state and result register.
// Depends on rrpa_pkg and rrpa_slot_eval.
`timescale 1ns / 1ps

// Round-robin pool allocator with per-slot health tracking. Each slot keeps a busy flag and
// a failure count that saturates at 15; a slot with 3 or more failures counts as failed.
// One item is taken at a time (in_stall is high from the cycle after a transfer until the
// result is loaded) and yields exactly one result. All slot work runs one slot per cycle
// through the shared rrpa_slot_eval unit. With S = min(pool_size, MAX_SLOTS), the states
// that an item runs through after its transfer are:
//   acquire          : POINT (F pointer fold steps, F = 0 unless pool_size shrank below the
//                      pointer since the last acquire), SCAN (up to S slots), TALLY, DONE
//   release, failure : SLOT, TALLY, DONE
//   health tick      : TICK (S slots), TALLY, DONE
//   S = 0            : only TALLY and DONE for acquire and health tick
// TALLY counts available, busy and failed slots. A result waits in the output
// register while the next item is taken. pool_size is written through cfg_we/cfg_wdata and
// may only change while no item is in flight; slots at or above it keep their state.
module round_robin_pool_allocator #(
	parameter int unsigned MAX_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [2:0] slot_index,
	input  logic [7:0] ready_mask,
	input  logic [7:0] reset_ok_mask,
	input  logic [7:0] recreate_ok_mask,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       granted,
	output logic [2:0] grant_index,
	output logic [3:0] available_count,
	output logic [3:0] busy_count,
	output logic [3:0] failed_count
);

	// The 4-bit pool size never reaches past slot 14, so deeper pools store nothing more.
	localparam int unsigned DEPTH  = (MAX_SLOTS < rrpa_pkg::CFG_SIZE_MAX) ?
	                                 MAX_SLOTS : rrpa_pkg::CFG_SIZE_MAX;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rrpa_pkg::state_t  state_q, state_d;

	// slot state
	logic              busy_flags_q [DEPTH];
	logic [3:0]        fail_cnt_q   [DEPTH];

	// configuration and pointer
	logic [3:0]        pool_size_q;
	logic [CNT_W-1:0]  ptr_q;

	// latched item
	rrpa_pkg::action_t action_q;
	logic [2:0]        slot_q;
	logic [7:0]        ready_q;
	logic [7:0]        reset_ok_q;
	logic [7:0]        recreate_q;
	logic [CNT_W-1:0]  size_q;

	// sequencer working registers
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  steps_q;
	logic              grant_q;
	logic [CNT_W-1:0]  gidx_q;
	logic [CNT_W-1:0]  n_avail_q;
	logic [CNT_W-1:0]  n_busy_q;
	logic [CNT_W-1:0]  n_fail_q;

	// result register
	logic              out_valid_q;
	logic              out_grant_q;
	logic [2:0]        out_gidx_q;
	logic [3:0]        out_avail_q;
	logic [3:0]        out_busy_q;
	logic [3:0]        out_fail_q;

	logic              in_xfer;
	logic              out_free;
	logic [CNT_W-1:0]  size_d;
	logic [CNT_W-1:0]  size_last;
	logic              idx_last;
	logic              steps_last;
	logic              slot_in_range;
	logic [3:0]        cur_idx;
	logic [SLOT_W-1:0] cur_sel;
	logic              slot_we;

	rrpa_pkg::action_t   eval_op;
	rrpa_pkg::slot_in_t  eval_in;
	rrpa_pkg::slot_res_t eval_res;

	assign in_stall = (state_q != rrpa_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// clamp the configured size to the slots that exist
	assign size_d = (pool_size_q > 4'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(pool_size_q);

	assign size_last     = size_q - CNT_W'(1);
	assign idx_last      = (idx_q == size_last);
	assign steps_last    = (steps_q == size_last);
	assign slot_in_range = ({1'b0, slot_q} < 4'(size_q));

	// one slot under evaluation per cycle: the named slot, or the scan/sweep index
	assign cur_idx = (state_q == rrpa_pkg::ST_SLOT) ? {1'b0, slot_q} : 4'(idx_q);
	assign cur_sel = cur_idx[SLOT_W-1:0];

	always_comb begin
		case (state_q)
			rrpa_pkg::ST_SLOT: eval_op = action_q;
			rrpa_pkg::ST_TICK: eval_op = rrpa_pkg::ACT_TICK;
			default:           eval_op = rrpa_pkg::ACT_ACQUIRE;
		endcase
	end

	assign eval_in.busy        = busy_flags_q[cur_sel];
	assign eval_in.count       = fail_cnt_q[cur_sel];
	assign eval_in.ready       = rrpa_pkg::mask_bit(ready_q, cur_idx);
	assign eval_in.reset_ok    = rrpa_pkg::mask_bit(reset_ok_q, cur_idx);
	assign eval_in.recreate_ok = rrpa_pkg::mask_bit(recreate_q, cur_idx);

	rrpa_slot_eval u_slot_eval (
		.op   (eval_op),
		.slot (eval_in),
		.res  (eval_res)
	);

	// write back only in the states that change a slot; the tally only reads
	always_comb begin
		case (state_q)
			rrpa_pkg::ST_SCAN: slot_we = eval_res.write;
			rrpa_pkg::ST_SLOT: slot_we = eval_res.write && slot_in_range;
			rrpa_pkg::ST_TICK: slot_we = eval_res.write;
			default:           slot_we = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrpa_pkg::ST_IDLE: begin
				if (in_xfer) begin
					case (rrpa_pkg::action_t'(action))
						rrpa_pkg::ACT_ACQUIRE: state_d = (size_d != '0) ?
						                                 rrpa_pkg::ST_POINT : rrpa_pkg::ST_TALLY;
						rrpa_pkg::ACT_TICK:    state_d = (size_d != '0) ?
						                                 rrpa_pkg::ST_TICK : rrpa_pkg::ST_TALLY;
						default:               state_d = rrpa_pkg::ST_SLOT;
					endcase
				end
			end
			rrpa_pkg::ST_POINT: begin
				if (ptr_q < size_q) state_d = rrpa_pkg::ST_SCAN;
			end
			rrpa_pkg::ST_SCAN: begin
				if (eval_res.hit || steps_last) state_d = rrpa_pkg::ST_TALLY;
			end
			rrpa_pkg::ST_SLOT: begin
				state_d = rrpa_pkg::ST_TALLY;
			end
			rrpa_pkg::ST_TICK: begin
				if (idx_last) state_d = rrpa_pkg::ST_TALLY;
			end
			rrpa_pkg::ST_TALLY: begin
				if ((size_q == '0) || idx_last) state_d = rrpa_pkg::ST_DONE;
			end
			rrpa_pkg::ST_DONE: begin
				if (out_free) state_d = rrpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = rrpa_pkg::ST_IDLE;
			end
		endcase
	end

	// slot state: cleared at reset, one entry written per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				busy_flags_q[i] <= 1'b0;
				fail_cnt_q[i]   <= 4'd0;
			end
		end else if (slot_we) begin
			busy_flags_q[cur_sel] <= eval_res.busy_nxt;
			fail_cnt_q[cur_sel]   <= eval_res.count_nxt;
		end
	end

	// configuration register, start pointer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= 4'd0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) pool_size_q <= cfg_wdata;

			case (state_q)
				rrpa_pkg::ST_POINT: begin
					// fold the pointer into the current pool, one subtraction per cycle
					if (ptr_q >= size_q) ptr_q <= ptr_q - size_q;
				end
				rrpa_pkg::ST_SCAN: begin
					// advance past the scan start whether or not a slot was granted
					if (eval_res.hit || steps_last) begin
						ptr_q <= (ptr_q == size_last) ? '0 : ptr_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase

			if ((state_q == rrpa_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item latch, scan and tally registers, result payload
	always_ff @(posedge clk) begin
		case (state_q)
			rrpa_pkg::ST_IDLE: begin
				if (in_xfer) begin
					action_q   <= rrpa_pkg::action_t'(action);
					slot_q     <= slot_index;
					ready_q    <= ready_mask;
					reset_ok_q <= reset_ok_mask;
					recreate_q <= recreate_ok_mask;
					size_q     <= size_d;
					idx_q      <= '0;
					steps_q    <= '0;
					grant_q    <= 1'b0;
					gidx_q     <= '0;
					n_avail_q  <= '0;
					n_busy_q   <= '0;
					n_fail_q   <= '0;
				end
			end
			rrpa_pkg::ST_POINT: begin
				// hold the scan start at the folded pointer
				idx_q   <= (ptr_q >= size_q) ? ptr_q - size_q : ptr_q;
				steps_q <= '0;
			end
			rrpa_pkg::ST_SCAN: begin
				if (eval_res.hit) begin
					grant_q <= 1'b1;
					gidx_q  <= idx_q;
					idx_q   <= '0;
				end else if (steps_last) begin
					idx_q <= '0;
				end else begin
					steps_q <= steps_q + CNT_W'(1);
					idx_q   <= idx_last ? '0 : idx_q + CNT_W'(1);
				end
			end
			rrpa_pkg::ST_SLOT: begin
				idx_q <= '0;
			end
			rrpa_pkg::ST_TICK: begin
				idx_q <= idx_last ? '0 : idx_q + CNT_W'(1);
			end
			rrpa_pkg::ST_TALLY: begin
				if (size_q != '0) begin
					if (eval_res.failed) begin
						n_fail_q <= n_fail_q + CNT_W'(1);
					end else if (eval_in.busy) begin
						n_busy_q <= n_busy_q + CNT_W'(1);
					end else begin
						n_avail_q <= n_avail_q + CNT_W'(1);
					end
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			rrpa_pkg::ST_DONE: begin
				if (out_free) begin
					out_grant_q <= grant_q;
					out_gidx_q  <= 3'(gidx_q);
					out_avail_q <= 4'(n_avail_q);
					out_busy_q  <= 4'(n_busy_q);
					out_fail_q  <= 4'(n_fail_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign granted         = out_grant_q;
	assign grant_index     = out_gidx_q;
	assign available_count = out_avail_q;
	assign busy_count      = out_busy_q;
	assign failed_count    = out_fail_q;

endmodule

// ----- rtl/rrpa_checker.sv -----
// Port-level checker of the round-robin pool allocator and its bind to the top level.
// Depends on round_robin_pool_allocator_assert.svh.
`timescale 1ns / 1ps
`include "round_robin_pool_allocator_assert.svh"

module rrpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       granted,
	input logic [2:0] grant_index,
	input logic [3:0] available_count,
	input logic [3:0] busy_count,
	input logic [3:0] failed_count
);

	// a taken item keeps the block busy for at least the next cycle
	`RRPA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

	// a result without a grant reports slot zero
	`RRPA_ASSERT_NOW(a_no_grant_index, out_valid && !granted, grant_index == 3'd0)

	// a granted slot is counted busy in the same result
	`RRPA_ASSERT_NOW(a_grant_is_busy, out_valid && granted, busy_count != 4'd0)

	// a stalled result holds
	`RRPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(granted) && $stable(grant_index) && $stable(available_count)
		&& $stable(busy_count) && $stable(failed_count))

endmodule

bind round_robin_pool_allocator rrpa_checker u_rrpa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.granted         (granted),
	.grant_index     (grant_index),
	.available_count (available_count),
	.busy_count      (busy_count),
	.failed_count    (failed_count)
);
